// ===== src/stid_pkg.sv =====
`default_nettype none
package stid_pkg;

	localparam int DEPTH        = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int KEY_BITS     = 32;
	localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int ENTRY_W      = KEY_BITS + PAYLOAD_BITS;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// Write port selection: address and data source of a table write.
	localparam logic [1:0] WR_UP     = 2'd0;
	localparam logic [1:0] WR_DOWN   = 2'd1;
	localparam logic [1:0] WR_NEW_J1 = 2'd2;
	localparam logic [1:0] WR_NEW_0  = 2'd3;

	localparam logic [1:0] POS_KEEP = 2'd0;
	localparam logic [1:0] POS_J    = 2'd1;
	localparam logic [1:0] POS_J1   = 2'd2;
	localparam logic [1:0] POS_ZERO = 2'd3;

	typedef struct packed {
		logic       load;
		logic       set_j_top;
		logic       set_j_zero;
		logic       j_inc;
		logic       j_dec;
		logic       rd_en;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic [1:0] pos_sel;
		logic       mark_found;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		logic [1:0] res_status;
	} stid_cmd_t;

	typedef struct packed {
		logic cnt_full;
		logic cnt_zero;
		logic key_lt;
		logic key_eq;
		logic j_zero;
		logic j_last;
		logic found;
	} stid_sts_t;

endpackage
`default_nettype wire

// ===== src/stid_ram.sv =====
`default_nettype none
module stid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                             wr_data,
	input  wire logic                                         rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/stid_ctrl.sv =====
`default_nettype none
module stid_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 mode,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire stid_pkg::stid_sts_t  sts,
	output stid_pkg::stid_cmd_t       cmd,
	output logic                      busy
);
	import stid_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RD    = 2'd1;
	localparam logic [1:0] S_CHK   = 2'd2;
	localparam logic [1:0] S_WRNEW = 2'd3;

	logic [1:0] state_q, state_d;
	logic       mode_q;
	logic       out_valid_q;
	logic       accept;

	assign busy      = (state_q != S_IDLE);
	assign in_stall  = busy || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (!mode) begin
						if (sts.cnt_full) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_FULL;
						end else if (sts.cnt_zero) begin
							state_d = S_WRNEW;
						end else begin
							cmd.set_j_top = 1'b1;
							state_d       = S_RD;
						end
					end else begin
						if (sts.cnt_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.set_j_zero = 1'b1;
							state_d        = S_RD;
						end
					end
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHK;
			end
			S_CHK: begin
				if (!mode_q) begin
					// Walk down from the top; every greater key moves up one place.
					if (sts.key_lt) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_UP;
						if (sts.j_zero) begin
							state_d = S_WRNEW;
						end else begin
							cmd.j_dec = 1'b1;
							state_d   = S_RD;
						end
					end else begin
						cmd.wr_en      = 1'b1;
						cmd.wr_sel     = WR_NEW_J1;
						cmd.pos_sel    = POS_J1;
						cmd.cnt_inc    = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_DONE;
						state_d        = S_IDLE;
					end
				end else begin
					// Walk up from the bottom; after the match every entry moves down.
					if (sts.found) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_DOWN;
					end else if (sts.key_eq) begin
						cmd.mark_found = 1'b1;
						cmd.pos_sel    = POS_J;
					end
					if (sts.j_last) begin
						cmd.res_load = 1'b1;
						if (sts.found || sts.key_eq) begin
							cmd.cnt_dec    = 1'b1;
							cmd.res_status = ST_DONE;
						end else begin
							cmd.res_status = ST_ABSENT;
						end
						state_d = S_IDLE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_RD;
					end
				end
			end
			S_WRNEW: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_NEW_0;
				cmd.pos_sel    = POS_ZERO;
				cmd.cnt_inc    = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_DONE;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= mode;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/stid_dp.sv =====
`default_nettype none
module stid_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic signed [31:0]   key,
	input  wire logic        [31:0]   payload,
	input  wire stid_pkg::stid_cmd_t  cmd,
	output stid_pkg::stid_sts_t       sts,
	output logic             [1:0]    status,
	output logic             [5:0]    position,
	output logic             [6:0]    entry_count
);
	import stid_pkg::*;

	logic signed [KEY_BITS-1:0]     req_key_q;
	logic        [PAYLOAD_BITS-1:0] req_pay_q;
	logic        [IDX_W-1:0]        j_q;
	logic        [IDX_W-1:0]        pos_q;
	logic                           found_q;
	logic        [CNT_W-1:0]        cnt_q;
	logic        [1:0]              status_q;
	logic        [5:0]              position_q;
	logic        [6:0]              entry_count_q;

	logic        [CNT_W-1:0]        cnt_m1;
	logic        [IDX_W-1:0]        j_p1, j_m1;
	logic        [IDX_W-1:0]        pos_next;
	logic        [CNT_W-1:0]        cnt_next;
	logic        [ENTRY_W-1:0]      rd_data;
	logic signed [KEY_BITS-1:0]     rd_key;
	logic        [ENTRY_W-1:0]      new_entry;
	logic                           wr_en;
	logic        [IDX_W-1:0]        wr_addr;
	logic        [ENTRY_W-1:0]      wr_data;

	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign j_p1      = j_q + IDX_W'(1);
	assign j_m1      = j_q - IDX_W'(1);
	assign rd_key    = rd_data[ENTRY_W-1 -: KEY_BITS];
	assign new_entry = {req_key_q, req_pay_q};

	assign sts.cnt_full = (cnt_q == CNT_W'(DEPTH));
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.key_lt   = (req_key_q < rd_key);
	assign sts.key_eq   = (req_key_q == rd_key);
	assign sts.j_zero   = (j_q == '0);
	assign sts.j_last   = (j_q == cnt_m1[IDX_W-1:0]);
	assign sts.found    = found_q;

	always_comb begin
		wr_en = cmd.wr_en;
		case (cmd.wr_sel)
			WR_UP: begin
				wr_addr = j_p1;
				wr_data = rd_data;
			end
			WR_DOWN: begin
				wr_addr = j_m1;
				wr_data = rd_data;
			end
			WR_NEW_J1: begin
				wr_addr = j_p1;
				wr_data = new_entry;
			end
			default: begin
				wr_addr = '0;
				wr_data = new_entry;
			end
		endcase
	end

	always_comb begin
		case (cmd.pos_sel)
			POS_J:    pos_next = j_q;
			POS_J1:   pos_next = j_p1;
			POS_ZERO: pos_next = '0;
			default:  pos_next = pos_q;
		endcase
	end

	always_comb begin
		if (cmd.cnt_inc) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			cnt_next = cnt_m1;
		end else begin
			cnt_next = cnt_q;
		end
	end

	stid_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (j_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.mark_found) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_key_q <= key;
			req_pay_q <= PAYLOAD_BITS'(payload);
		end
		if (cmd.set_j_top) begin
			j_q <= cnt_m1[IDX_W-1:0];
		end else if (cmd.set_j_zero) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= j_p1;
		end else if (cmd.j_dec) begin
			j_q <= j_m1;
		end
		pos_q <= pos_next;
		if (cmd.res_load) begin
			status_q      <= cmd.res_status;
			position_q    <= (cmd.res_status == ST_DONE) ? 6'(pos_next) : 6'd0;
			entry_count_q <= 7'(cnt_next);
		end
	end

	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

// ===== src/sorted_table_insert_delete_top.sv =====
`default_nettype none
// Channel   Handshake            Fields
// request   in_valid / in_stall  mode, key, payload
// result    out_valid/ out_stall status, position, entry_count
//
// A request visits one table entry at a time through the read port of the entry RAM,
// with a read state and a check state per entry. An insert walks down from the top,
// moving every greater key up, and stops at the first key that is not greater; when
// every stored key is greater, it writes the new entry at position zero. A delete walks
// the whole table. Full and empty are answered at the accepting edge itself.
// Reset clears the entry count and the found flag, not the entries; entries are never read
// before they are written. A new request is taken once the previous one is finished and its
// result beat is taken or is being taken in the same cycle.
module sorted_table_insert_delete_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic signed [31:0] key,
	input  wire logic        [31:0] payload,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [1:0]  status,
	output logic             [5:0]  position,
	output logic             [6:0]  entry_count
);
	import stid_pkg::*;

	stid_cmd_t cmd;
	stid_sts_t sts;
	logic      busy;

	stid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	stid_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.payload     (payload),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

`ifndef SYNTH
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (busy || out_valid))
		else $error("accepted request neither in progress nor answered");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> busy)
		else $error("table write while idle");

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.cnt_full && sts.cnt_zero))
		else $error("entry count both full and empty");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && cmd.res_load) |-> (!out_valid || !out_stall))
		else $error("result overwrites a pending beat");
`endif

endmodule
`default_nettype wire

// ===== test/tb_sorted_table_insert_delete_top.sv =====
`timescale 1ns / 1ps
module tb_sorted_table_insert_delete_top;
	import stid_pkg::*;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	localparam int NUM_RANDOM  = 2000;
	localparam int QUIET_ITEMS = 150;
	localparam int HOLD_LEN    = 400;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] key;
		logic [31:0]        payload;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] position;
		logic [6:0] entry_count;
	} outcome_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] key;
		logic [31:0]        payload;
		logic               given;
		logic [1:0]         status;
		logic [5:0]         position;
		logic [6:0]         entry_count;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = 1'b0;
	logic signed [31:0] key = '0;
	logic [31:0]        payload = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [5:0]         position;
	logic [6:0]         entry_count;

	bit quiet_tail = 1'b0;
	int mismatch_count = 0;

	// Shadow copy of the sorted table, kept in step with accepted requests.
	logic signed [31:0] row_keys [DEPTH];
	logic [31:0]        row_pays [DEPTH];
	int                 row_count = 0;

	outcome_t pending_results[$];

	// Expected results are typed in only where they follow directly from the table contents.
	plan_row_t plan [0:19] = '{
		'{OP_DELETE, 32'sd0,          32'h0000_0000, 1'b1, ST_EMPTY,  6'd0, 7'd0},
		'{OP_INSERT, 32'sd0,          32'h0000_0000, 1'b1, ST_DONE,   6'd0, 7'd1},
		'{OP_INSERT, KEY_MAX,         32'hffff_ffff, 1'b1, ST_DONE,   6'd1, 7'd2},
		'{OP_INSERT, KEY_MIN,         32'haaaa_aaaa, 1'b1, ST_DONE,   6'd0, 7'd3},
		'{OP_INSERT, -32'sd1,         32'h5555_5555, 1'b1, ST_DONE,   6'd1, 7'd4},
		'{OP_INSERT, 32'sd0,          32'h0000_0001, 1'b1, ST_DONE,   6'd3, 7'd5},
		'{OP_DELETE, 32'sd5,          32'h0000_0000, 1'b1, ST_ABSENT, 6'd0, 7'd5},
		'{OP_INSERT, KEY_MIN,         32'h1234_5678, 1'b1, ST_DONE,   6'd1, 7'd6},
		'{OP_INSERT, KEY_MAX,         32'h0000_0000, 1'b1, ST_DONE,   6'd6, 7'd7},
		'{OP_DELETE, 32'sd0,          32'hffff_ffff, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, KEY_MAX,         32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, KEY_MIN,         32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, 32'sh7fff_fffe,  32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_INSERT, 32'sh7fff_fffe,  32'h8000_0001, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, -32'sd1,         32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, 32'sd0,          32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, KEY_MAX,         32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, 32'sh7fff_fffe,  32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, KEY_MIN,         32'h0000_0000, 1'b0, ST_DONE,   6'd0, 7'd0},
		'{OP_DELETE, -32'sd1,         32'h0000_0000, 1'b1, ST_EMPTY,  6'd0, 7'd0}
	};

	sorted_table_insert_delete_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.key         (key),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	always #6 clk = ~clk;

	function automatic outcome_t apply_to_table(input request_t r);
		outcome_t res;
		int       slot;
		int       j;
		res.status = ST_DONE;
		res.position = '0;
		slot = 0;
		if (r.mode == OP_INSERT) begin
			if (row_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// Equal keys go after the ones already stored.
				while (slot < row_count && $signed(r.key) >= $signed(row_keys[slot]))
					slot++;
				for (j = row_count; j > slot; j--) begin
					row_keys[j] = row_keys[j - 1];
					row_pays[j] = row_pays[j - 1];
				end
				row_keys[slot] = r.key;
				row_pays[slot] = r.payload;
				row_count++;
				res.position = slot[5:0];
			end
		end else if (row_count == 0) begin
			res.status = ST_EMPTY;
		end else begin
			while (slot < row_count && row_keys[slot] != r.key)
				slot++;
			if (slot >= row_count) begin
				res.status = ST_ABSENT;
			end else begin
				for (j = slot; j + 1 < row_count; j++) begin
					row_keys[j] = row_keys[j + 1];
					row_pays[j] = row_pays[j + 1];
				end
				row_count--;
				res.position = slot[5:0];
			end
		end
		res.entry_count = row_count[6:0];
		return res;
	endfunction

	function automatic logic signed [31:0] pick_key(input bit from_table);
		logic signed [31:0] k;
		if (from_table && row_count > 0) begin
			k = row_keys[$urandom_range(0, row_count - 1)];
		end else begin
			case ($urandom_range(0, 3))
				0: k = KEY_MIN + $urandom_range(0, 3);
				1: k = KEY_MAX - $urandom_range(0, 3);
				2: k = int'($urandom_range(0, 12)) - 6;
				default: k = $urandom;
			endcase
		end
		return k;
	endfunction

	task automatic offer_request(input request_t r, input bit use_given, input outcome_t given);
		outcome_t predicted;
		bit       taken;
		in_valid <= 1'b1;
		mode <= r.mode;
		key <= r.key;
		payload <= r.payload;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		predicted = apply_to_table(r);
		pending_results.push_back(use_given ? given : predicted);
	endtask

	initial begin : stimulus
		plan_row_t row;
		request_t  r;
		outcome_t  given;
		phase_e    kind;
		int        phase_len;
		int        sent;
		int        step_i;
		int        waited;
		bit        del;
		bit        tail;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			row = plan[i];
			r.mode = row.mode;
			r.key = row.key;
			r.payload = row.payload;
			given.status = row.status;
			given.position = row.position;
			given.entry_count = row.entry_count;
			offer_request(r, row.given, given);
		end
		// Random phases that fill the table toward full, drain it toward empty, or mix the two.
		sent = 0;
		while (sent < NUM_RANDOM) begin
			kind = phase_e'($urandom_range(0, 2));
			phase_len = (kind == PH_MIX) ? $urandom_range(20, 80) : $urandom_range(70, 110);
			for (step_i = 0; step_i < phase_len && sent < NUM_RANDOM; step_i++) begin
				tail = (sent >= NUM_RANDOM - QUIET_ITEMS);
				quiet_tail <= tail;
				if (!tail && $urandom_range(0, 7) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
				case (kind)
					PH_FILL:  del = ($urandom_range(0, 9) == 0);
					PH_DRAIN: del = ($urandom_range(0, 9) != 0);
					default:  del = $urandom_range(0, 1);
				endcase
				r.mode = del ? OP_DELETE : OP_INSERT;
				r.key = pick_key(del && $urandom_range(0, 5) != 0);
				r.payload = $urandom;
				offer_request(r, 1'b0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : result_stall
		int cyc;
		int holds;
		int n;
		cyc = 0;
		holds = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!quiet_tail && holds < 2 && cyc >= 5000 + holds * 50000) begin
				// Long hold-off so that the block backs up and stalls its request side.
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				cyc += HOLD_LEN;
				holds++;
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				cyc += n;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				n = $urandom_range(50, 200);
				repeat (n) @(posedge clk);
				cyc += n;
			end
		end
	end

	initial begin : result_check
		outcome_t got;
		outcome_t want;
		forever begin
			@(negedge clk);
			if (out_valid && !out_stall) begin
				got.status = status;
				got.position = position;
				got.entry_count = entry_count;
				@(posedge clk);
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d position %0d count %0d",
						$time, got.status, got.position, got.entry_count);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, got.status);
						mismatch_count++;
					end
					if (got.position !== want.position) begin
						$display("%0t: position mismatch, expected %0d, got %0d",
							$time, want.position, got.position);
						mismatch_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count mismatch, expected %0d, got %0d",
							$time, want.entry_count, got.entry_count);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
src/stid_pkg.sv
src/stid_ram.sv
src/stid_ctrl.sv
src/stid_dp.sv
src/sorted_table_insert_delete_top.sv
test/tb_sorted_table_insert_delete_top.sv
